// ----- design/cma_pkg.sv -----
// Package for the cubic misorientation angle unit.
// Holds widths, stage payload types and the elaboration-time arc cosine table builder.
// Depends on nothing.
package cma_pkg;

    localparam int ACOS_TABLE_BITS_DEF = 10;
    localparam int MAG_W = 33;
    localparam int SUM_W = 34;
    localparam int PROD_W = SUM_W + 24;
    localparam logic [23:0] RSQRT2_Q24 = 24'd11863283;
    localparam logic [SUM_W-1:0] ONE_Q28 = SUM_W'(64'd1 << 28);
    localparam logic [14:0] COS_ONE = 15'd16384;
    localparam int FULL_ANGLE = 46080;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic signed [15:0] q_t;
    typedef logic [MAG_W-1:0] mag_t;

    // Four magnitudes of the relative quaternion.
    typedef struct packed {
        mag_t m0;
        mag_t m1;
        mag_t m2;
        mag_t m3;
    } mag4_t;

    // Result of one item.
    typedef struct packed {
        logic [14:0] half_angle_cos;
        logic [15:0] angle_deg;
    } angle_res_t;

    // Cosine of a/512 degrees in Q1.30, twelve-term Taylor series with 64-bit wrap.
    // Term n is divided by (2n-1)(2n), written out as a constant for each term.
    function automatic longint cos_of_full(input longint unsigned a);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned prod;
        longint sum;
        x = (a * PI_Q30 + 64'd46080) / 64'd92160;
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        sum = longint'(term);
        for (int n = 1; n <= 12; n++)
        begin
            prod = (term * x2) >> 30;
            unique case (n)
                1:       term = prod / 64'd2;
                2:       term = prod / 64'd12;
                3:       term = prod / 64'd30;
                4:       term = prod / 64'd56;
                5:       term = prod / 64'd90;
                6:       term = prod / 64'd132;
                7:       term = prod / 64'd182;
                8:       term = prod / 64'd240;
                9:       term = prod / 64'd306;
                10:      term = prod / 64'd380;
                11:      term = prod / 64'd462;
                default: term = prod / 64'd552;
            endcase
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return sum;
    endfunction

    // Table entry: the Q8.8 angle whose cosine lies nearest to i / 2^bits.
    function automatic logic [15:0] acos_entry(input int i, input int bits);
        longint target;
        longint lo;
        longint hi;
        longint mid;
        target = longint'(i) << (30 - bits);
        lo = 0;
        hi = FULL_ANGLE;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (cos_of_full(mid) <= target)
                hi = mid;
            else
                lo = mid + 1;
        end
        if (lo > 0 && (cos_of_full(lo - 1) - target) < (target - cos_of_full(lo)))
            lo = lo - 1;
        return 16'(lo);
    endfunction

endpackage

// ----- design/cma_quat_if.sv -----
// Input channel of the misorientation unit: a pair of Q2.14 quaternions.
// Depends on nothing.
interface cma_quat_if;
    logic valid;
    logic ready;
    logic signed [15:0] first_w;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;

    modport source (output valid, first_w, first_x, first_y, first_z,
                    second_w, second_x, second_y, second_z, input ready);
    modport sink (input valid, first_w, first_x, first_y, first_z,
                  second_w, second_x, second_y, second_z, output ready);
endinterface

// ----- design/cma_angle_if.sv -----
// Output channel of the misorientation unit: half-angle cosine and angle.
// Depends on nothing.
interface cma_angle_if;
    logic valid;
    logic ready;
    logic [14:0] half_angle_cos;
    logic [15:0] angle_deg;

    modport source (output valid, half_angle_cos, angle_deg, input ready);
    modport sink (input valid, half_angle_cos, angle_deg, output ready);
endinterface

// ----- design/cma_product.sv -----
// Two stages: sixteen partial products, then the four component sums and their magnitudes.
// Depends on cma_pkg.
module cma_product (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cma_pkg::q_t    w1,
    input  cma_pkg::q_t    x1,
    input  cma_pkg::q_t    y1,
    input  cma_pkg::q_t    z1,
    input  cma_pkg::q_t    w2,
    input  cma_pkg::q_t    x2,
    input  cma_pkg::q_t    y2,
    input  cma_pkg::q_t    z2,
    output logic           out_valid,
    input  logic           out_ready,
    output cma_pkg::mag4_t out_mag
);
    import cma_pkg::*;

    logic signed [31:0] prod_reg [16];
    logic               v1_reg;
    logic               v2_reg;
    mag4_t              mag_reg;
    logic               rdy1;
    logic               rdy2;
    logic signed [SUM_W-1:0] s0;
    logic signed [SUM_W-1:0] s1;
    logic signed [SUM_W-1:0] s2;
    logic signed [SUM_W-1:0] s3;
    mag4_t              mag_next;

    // A stage may load when it is empty or its content moves on.
    assign rdy2 = !v2_reg || out_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage one: all products of the Hamilton product of conj(q1) and q2.
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            prod_reg[0]  <= w1 * w2;
            prod_reg[1]  <= x1 * x2;
            prod_reg[2]  <= y1 * y2;
            prod_reg[3]  <= z1 * z2;
            prod_reg[4]  <= w1 * x2;
            prod_reg[5]  <= w2 * x1;
            prod_reg[6]  <= y1 * z2;
            prod_reg[7]  <= z1 * y2;
            prod_reg[8]  <= w1 * y2;
            prod_reg[9]  <= w2 * y1;
            prod_reg[10] <= z1 * x2;
            prod_reg[11] <= x1 * z2;
            prod_reg[12] <= w1 * z2;
            prod_reg[13] <= w2 * z1;
            prod_reg[14] <= x1 * y2;
            prod_reg[15] <= y1 * x2;
        end
    end

    // Stage two: component sums and magnitudes.
    always_comb
    begin
        s0 = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
             + SUM_W'(prod_reg[3]);
        s1 = SUM_W'(prod_reg[4]) - SUM_W'(prod_reg[5])
             - (SUM_W'(prod_reg[6]) - SUM_W'(prod_reg[7]));
        s2 = SUM_W'(prod_reg[8]) - SUM_W'(prod_reg[9])
             - (SUM_W'(prod_reg[10]) - SUM_W'(prod_reg[11]));
        s3 = SUM_W'(prod_reg[12]) - SUM_W'(prod_reg[13])
             - (SUM_W'(prod_reg[14]) - SUM_W'(prod_reg[15]));
        mag_next.m0 = s0[SUM_W-1] ? MAG_W'(-s0) : MAG_W'(s0);
        mag_next.m1 = s1[SUM_W-1] ? MAG_W'(-s1) : MAG_W'(s1);
        mag_next.m2 = s2[SUM_W-1] ? MAG_W'(-s2) : MAG_W'(s2);
        mag_next.m3 = s3[SUM_W-1] ? MAG_W'(-s3) : MAG_W'(s3);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
            mag_reg <= mag_next;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_mag = mag_reg;

endmodule

// ----- design/cma_cosine.sv -----
// Three stages: sort of the magnitudes, symmetry variant sums with the root-two multiply,
// and the maximum with saturation and rounding to Q2.14. Depends on cma_pkg.
module cma_cosine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cma_pkg::mag4_t in_mag,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [14:0]    out_cos
);
    import cma_pkg::*;

    logic              v3_reg;
    logic              v4_reg;
    logic              v5_reg;
    logic              rdy3;
    logic              rdy4;
    logic              rdy5;
    mag4_t             srt_reg;
    mag4_t             srt_next;
    mag_t              top_reg;
    logic [PROD_W-1:0] scaled_reg;
    logic [SUM_W-1:0]  half_reg;
    logic [14:0]       cos_reg;
    logic [14:0]       cos_next;
    mag_t              p0;
    mag_t              p1;
    mag_t              p2;
    mag_t              p3;
    mag_t              q0;
    mag_t              q1;
    mag_t              q2;
    mag_t              q3;
    logic [SUM_W-1:0]  pair_sum;
    logic [SUM_W:0]    all_sum;
    logic [PROD_W-1:0] rounded;
    logic [SUM_W-1:0]  pair_var;
    logic [SUM_W-1:0]  best;
    logic [SUM_W-1:0]  best_rnd;

    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign in_ready = rdy3;

    // Stage three: five compare-exchange network, largest first.
    always_comb
    begin
        p0 = (in_mag.m0 >= in_mag.m1) ? in_mag.m0 : in_mag.m1;
        p1 = (in_mag.m0 >= in_mag.m1) ? in_mag.m1 : in_mag.m0;
        p2 = (in_mag.m2 >= in_mag.m3) ? in_mag.m2 : in_mag.m3;
        p3 = (in_mag.m2 >= in_mag.m3) ? in_mag.m3 : in_mag.m2;
        q0 = (p0 >= p2) ? p0 : p2;
        q2 = (p0 >= p2) ? p2 : p0;
        q1 = (p1 >= p3) ? p1 : p3;
        q3 = (p1 >= p3) ? p3 : p1;
        srt_next.m0 = q0;
        srt_next.m1 = (q1 >= q2) ? q1 : q2;
        srt_next.m2 = (q1 >= q2) ? q2 : q1;
        srt_next.m3 = q3;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
            srt_reg <= srt_next;
    end

    // Stage four: pair sum times one over root two, and half of the full sum.
    always_comb
    begin
        pair_sum = SUM_W'(srt_reg.m0) + SUM_W'(srt_reg.m1);
        all_sum = (SUM_W+1)'(srt_reg.m0) + (SUM_W+1)'(srt_reg.m1)
                  + (SUM_W+1)'(srt_reg.m2) + (SUM_W+1)'(srt_reg.m3);
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            top_reg <= srt_reg.m0;
            scaled_reg <= PROD_W'(pair_sum) * PROD_W'(RSQRT2_Q24);
            half_reg <= all_sum[SUM_W:1];
        end
    end

    // Stage five: round the scaled pair, take the maximum, saturate and round to Q2.14.
    always_comb
    begin
        rounded = scaled_reg + PROD_W'(64'd1 << 23);
        pair_var = rounded[PROD_W-1:24];
        best = SUM_W'(top_reg);
        if (pair_var > best)
            best = pair_var;
        if (half_reg > best)
            best = half_reg;
        best_rnd = best + SUM_W'(8192);
        if (best >= ONE_Q28)
            cos_next = COS_ONE;
        else
            cos_next = best_rnd[28:14];
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
            cos_reg <= cos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
                v3_reg <= in_valid;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_cos = cos_reg;

endmodule

// ----- design/cma_acos_lut.sv -----
// Two stages: arc cosine table read at two neighbouring entries, then linear
// interpolation into the output register. Depends on cma_pkg.
module cma_acos_lut #(
    parameter int ACOS_TABLE_BITS = cma_pkg::ACOS_TABLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [14:0]         in_cos,
    output logic                out_valid,
    input  logic                out_ready,
    output cma_pkg::angle_res_t out_res
);
    import cma_pkg::*;

    localparam int TABLE_LEN = (1 << ACOS_TABLE_BITS) + 1;
    localparam int POS_W = 15 + ACOS_TABLE_BITS;

    logic [15:0]                rom [TABLE_LEN];
    logic                       v6_reg;
    logic                       v7_reg;
    logic                       rdy6;
    logic                       rdy7;
    logic [15:0]                t0_reg;
    logic [15:0]                t1_reg;
    logic [13:0]                frac_reg;
    logic [14:0]                cos_reg;
    angle_res_t                 res_reg;
    angle_res_t                 res_next;
    logic [POS_W-1:0]           pos;
    logic [ACOS_TABLE_BITS:0]   idx;
    logic [ACOS_TABLE_BITS:0]   idx_nb;
    logic [15:0]                diff;
    logic [29:0]                step;

    // Constant table worked out at elaboration.
    for (genvar g = 0; g < TABLE_LEN; g++)
    begin : g_rom
        localparam logic [15:0] ENTRY = acos_entry(g, ACOS_TABLE_BITS);
        assign rom[g] = ENTRY;
    end

    assign rdy7 = !v7_reg || out_ready;
    assign rdy6 = !v6_reg || rdy7;
    assign in_ready = rdy6;

    // Stage six: split the cosine into table index and 14-bit fraction.
    always_comb
    begin
        pos = POS_W'(in_cos) << ACOS_TABLE_BITS;
        idx = pos[POS_W-1:14];
        idx_nb = idx[ACOS_TABLE_BITS] ? idx : idx + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && in_valid)
        begin
            t0_reg <= rom[idx];
            t1_reg <= rom[idx_nb];
            frac_reg <= idx[ACOS_TABLE_BITS] ? 14'd0 : pos[13:0];
            cos_reg <= in_cos;
        end
    end

    // Stage seven: interpolate between the two entries; a cosine of one gives zero.
    always_comb
    begin
        diff = t0_reg - t1_reg;
        step = 30'(diff) * 30'(frac_reg) + 30'd8192;
        res_next.half_angle_cos = cos_reg;
        if (cos_reg >= COS_ONE)
            res_next.angle_deg = 16'd0;
        else
            res_next.angle_deg = t0_reg - 16'(step[29:14]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy7 && v6_reg)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy6)
                v6_reg <= in_valid;
            if (rdy7)
                v7_reg <= v6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign out_res = res_reg;

endmodule

// ----- design/cubic_misorientation_angle_unit.sv -----
// Channel | Direction | Payload
// quat    | in        | first_w..z, second_w..z, Q2.14 signed
// angle   | out       | half_angle_cos Q2.14, angle_deg Q8.8 degrees
//
// Seven register stages lie between transfer in and result. One item may enter every
// cycle unless the output stalls; products, sort, root-two multiply and table read
// each occupy their own stage. Every stage has its own valid bit, so a stalled output
// holds its result while empty stages upstream keep filling. Reset clears valid bits only.
// Top level of the cubic misorientation angle unit. Depends on cma_pkg, the two
// channel interfaces and the three pipeline section modules.
module cubic_misorientation_angle_unit #(
    parameter int ACOS_TABLE_BITS = cma_pkg::ACOS_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cma_quat_if.sink    quat,
    cma_angle_if.source angle
);
    import cma_pkg::*;

    logic       prd_valid;
    logic       prd_ready;
    mag4_t      prd_mag;
    logic       cos_valid;
    logic       cos_ready;
    logic [14:0] cos_val;
    angle_res_t res;

    // Products and magnitudes.
    cma_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quat.valid),
        .in_ready  (quat.ready),
        .w1        (quat.first_w),
        .x1        (quat.first_x),
        .y1        (quat.first_y),
        .z1        (quat.first_z),
        .w2        (quat.second_w),
        .x2        (quat.second_x),
        .y2        (quat.second_y),
        .z2        (quat.second_z),
        .out_valid (prd_valid),
        .out_ready (prd_ready),
        .out_mag   (prd_mag)
    );

    // Sort and best symmetry variant.
    cma_cosine u_cosine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prd_valid),
        .in_ready  (prd_ready),
        .in_mag    (prd_mag),
        .out_valid (cos_valid),
        .out_ready (cos_ready),
        .out_cos   (cos_val)
    );

    // Arc cosine lookup and output register.
    cma_acos_lut #(
        .ACOS_TABLE_BITS (ACOS_TABLE_BITS)
    ) u_acos_lut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cos_valid),
        .in_ready  (cos_ready),
        .in_cos    (cos_val),
        .out_valid (angle.valid),
        .out_ready (angle.ready),
        .out_res   (res)
    );

    assign angle.half_angle_cos = res.half_angle_cos;
    assign angle.angle_deg = res.angle_deg;

endmodule

// ----- design/cma_checker.sv -----
// Port-level checker for the cubic misorientation angle unit, with its bind.
// Depends on the top level and its output channel.
module cma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] half_angle_cos,
    input logic [15:0] angle_deg
);

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(half_angle_cos)
        && $stable(angle_deg))
        else $error("result changed while stalled");

    // The cosine never exceeds one.
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> half_angle_cos <= 15'd16384)
        else $error("cosine above one");

    // A saturated cosine gives a zero angle.
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && half_angle_cos == 15'd16384 |-> angle_deg == 16'd0)
        else $error("nonzero angle at cosine one");

    // The angle stays within a half turn.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_deg <= 16'd46080)
        else $error("angle above 180 degrees");

endmodule

bind cubic_misorientation_angle_unit cma_checker u_cma_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (angle.valid),
    .out_ready      (angle.ready),
    .half_angle_cos (angle.half_angle_cos),
    .angle_deg      (angle.angle_deg)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for cubic_misorientation_angle_unit.
// Depends on cma_pkg, cma_quat_if, cma_angle_if and the unit itself; it predicts each
// misorientation result independently and checks the output channel in order.
module tb_top;
    import cma_pkg::*;

    localparam int TAB_BITS = 10;
    localparam int TAB_LEN = (1 << TAB_BITS) + 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int NUM_RANDOM = 1080;
    localparam longint unsigned PI_Q30_TB = 64'd3373259426;
    localparam longint unsigned RT2_Q24 = 64'd11863283;
    localparam longint unsigned UNIT_Q28 = 64'd1 << 28;

    // One pair of orientations as offered on the input channel.
    typedef struct {
        q_t f[4];
        q_t s[4];
    } quat_pair_t;

    logic clk;
    logic rst_n;

    cma_quat_if quat ();
    cma_angle_if angle ();

    cubic_misorientation_angle_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat.sink),
        .angle (angle.source)
    );

    quat_pair_t pending_pairs[$];
    angle_res_t expected_angles[$];
    logic [15:0] acos_lut[0:TAB_LEN-1];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 0;
    bit stimulus_done = 0;

    // Clock with period 10.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cosine of a/512 degrees in Q1.30, Taylor series with 64-bit unsigned wrap.
    function automatic longint cos_half_deg(input longint unsigned a);
        longint unsigned x;
        longint unsigned xsq;
        longint unsigned term;
        longint unsigned divisor;
        longint acc;
        x = (a * PI_Q30_TB + 64'd46080) / 64'd92160;
        xsq = (x * x) >> 30;
        term = 64'd1 << 30;
        acc = longint'(term);
        for (int n = 1; n <= 12; n++)
        begin
            divisor = longint'((2 * n - 1) * (2 * n));
            term = ((term * xsq) >> 30) / divisor;
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    // Fill the arc cosine table: nearest angle, ties to the larger angle.
    task automatic fill_acos_lut();
        longint target;
        longint lo;
        longint hi;
        longint mid;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            target = longint'(i) << (30 - TAB_BITS);
            lo = 0;
            hi = FULL_ANGLE;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (cos_half_deg(mid) <= target)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            if (lo > 0 && (cos_half_deg(lo - 1) - target) < (target - cos_half_deg(lo)))
                lo = lo - 1;
            acos_lut[i] = 16'(lo);
        end
    endtask

    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Misorientation under cubic symmetry for one pair.
    function automatic angle_res_t misorientation(input quat_pair_t p);
        longint w1;
        longint x1;
        longint y1;
        longint z1;
        longint w2;
        longint x2;
        longint y2;
        longint z2;
        longint unsigned m[4];
        longint unsigned t;
        longint unsigned best;
        longint unsigned v;
        longint unsigned c;
        longint unsigned pos;
        longint unsigned frac;
        longint unsigned d;
        longint unsigned ang;
        int idx;
        angle_res_t r;
        w1 = p.f[0]; x1 = p.f[1]; y1 = p.f[2]; z1 = p.f[3];
        w2 = p.s[0]; x2 = p.s[1]; y2 = p.s[2]; z2 = p.s[3];
        m[0] = abs64(w1 * w2 + x1 * x2 + y1 * y2 + z1 * z2);
        m[1] = abs64(w1 * x2 - w2 * x1 - (y1 * z2 - z1 * y2));
        m[2] = abs64(w1 * y2 - w2 * y1 - (z1 * x2 - x1 * z2));
        m[3] = abs64(w1 * z2 - w2 * z1 - (x1 * y2 - y1 * x2));
        // Sort magnitudes in decreasing order.
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (m[j] < m[j + 1])
                begin
                    t = m[j];
                    m[j] = m[j + 1];
                    m[j + 1] = t;
                end
        best = m[0];
        v = ((m[0] + m[1]) * RT2_Q24 + (64'd1 << 23)) >> 24;
        if (v > best)
            best = v;
        v = (m[0] + m[1] + m[2] + m[3]) >> 1;
        if (v > best)
            best = v;
        if (best >= UNIT_Q28)
            c = 16384;
        else
            c = (best + 64'd8192) >> 14;
        if (c > 16384)
            c = 16384;
        // Table read with linear interpolation.
        pos = c << TAB_BITS;
        idx = int'(pos >> 14);
        frac = pos & 64'h3FFF;
        if (idx >= TAB_LEN - 1)
            ang = acos_lut[TAB_LEN - 1];
        else
        begin
            d = longint'(acos_lut[idx]) - longint'(acos_lut[idx + 1]);
            ang = acos_lut[idx] - ((d * frac + 64'd8192) >> 14);
        end
        if (c >= 16384)
            ang = 0;
        r.half_angle_cos = 15'(c);
        r.angle_deg = 16'(ang);
        return r;
    endfunction

    // Random orientation of roughly unit length.
    function automatic void rand_unit(output q_t q[4]);
        real comp[4];
        real norm;
        norm = 0.0;
        for (int k = 0; k < 4; k++)
        begin
            comp[k] = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
            norm = norm + comp[k] * comp[k];
        end
        if (norm < 1.0e-6)
        begin
            comp[0] = 1.0;
            norm = 1.0;
        end
        norm = $sqrt(norm);
        for (int k = 0; k < 4; k++)
            q[k] = q_t'($rtoi(comp[k] / norm * 16384.0 + (comp[k] < 0 ? -0.5 : 0.5)));
    endfunction

    function automatic quat_pair_t make_pair(input int fw, fx, fy, fz, sw, sx, sy, sz);
        quat_pair_t p;
        p.f[0] = q_t'(fw); p.f[1] = q_t'(fx); p.f[2] = q_t'(fy); p.f[3] = q_t'(fz);
        p.s[0] = q_t'(sw); p.s[1] = q_t'(sx); p.s[2] = q_t'(sy); p.s[3] = q_t'(sz);
        return p;
    endfunction

    // Stimulus: directed pairs first, then random ones.
    initial
    begin
        quat_pair_t p;
        int kind;
        fill_acos_lut();
        // Identical orientations give zero angle.
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0));
        // Opposite sign of the same orientation.
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, -16384, 0, 0, 0));
        // Cubic equivalents: 90 degree and 120 degree rotations collapse to zero.
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 11585, 11585, 0, 0));
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 8192, 8192, 8192, 8192));
        // Largest cubic misorientation, about 62.8 degrees.
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 13985, 5793, 5793, 2399));
        // Small and moderate rotations about one axis.
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 16383, 181, 0, 0));
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 15137, 0, 6270, 0));
        pending_pairs.push_back(make_pair(0, 16384, 0, 0, 0, 0, 0, 16384));
        // Zero inputs: cosine zero, the far end of the table.
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 0, 0, 0, 0));
        // Field extremes and non-unit inputs; some of them saturate.
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                          -32768, -32768, -32768, -32768));
        pending_pairs.push_back(make_pair(-16384, -16384, -16384, -16384,
                                          16384, 16384, 16384, 16384));
        pending_pairs.push_back(make_pair(-32768, 0, 0, 0, 0, 0, 0, 1));
        pending_pairs.push_back(make_pair(1, -1, 1, -1, -1, 1, -1, 1));
        pending_pairs.push_back(make_pair(16384, 0, 0, 0, 4000, 3000, 2000, 1000));
        // Random part: mostly unit pairs, some near-equal, some raw bit patterns.
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                rand_unit(p.f);
                rand_unit(p.s);
            end
            else if (kind < 16)
            begin
                rand_unit(p.f);
                for (int k = 0; k < 4; k++)
                    p.s[k] = p.f[k] + q_t'($urandom_range(0, 400)) - q_t'(200);
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    p.f[k] = q_t'($urandom);
                    p.s[k] = q_t'($urandom);
                end
            end
            pending_pairs.push_back(p);
        end
    end

    // Reset and initial input values.
    initial
    begin
        rst_n = 1'b0;
        quat.valid = 1'b0;
        quat.first_w = '0;
        quat.first_x = '0;
        quat.first_y = '0;
        quat.first_z = '0;
        quat.second_w = '0;
        quat.second_x = '0;
        quat.second_y = '0;
        quat.second_z = '0;
        angle.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int draw_gap();
        // At least three quarters of the items follow back to back.
        if ($urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Driver: predicts on each transfer in, then presents the next pair after its gap.
    always @(posedge clk)
    begin
        quat_pair_t p;
        if (rst_n)
        begin
            if (quat.valid && quat.ready)
            begin
                p.f[0] = quat.first_w; p.f[1] = quat.first_x;
                p.f[2] = quat.first_y; p.f[3] = quat.first_z;
                p.s[0] = quat.second_w; p.s[1] = quat.second_x;
                p.s[2] = quat.second_y; p.s[3] = quat.second_z;
                expected_angles.push_back(misorientation(p));
                send_gap = draw_gap();
            end
            if ((!quat.valid || quat.ready) && send_gap > 0)
            begin
                quat.valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (!quat.valid || quat.ready)
            begin
                if (pending_pairs.size() > 0)
                begin
                    p = pending_pairs.pop_front();
                    quat.first_w <= p.f[0]; quat.first_x <= p.f[1];
                    quat.first_y <= p.f[2]; quat.first_z <= p.f[3];
                    quat.second_w <= p.s[0]; quat.second_x <= p.s[1];
                    quat.second_y <= p.s[2]; quat.second_z <= p.s[3];
                    quat.valid <= 1'b1;
                end
                else
                begin
                    quat.valid <= 1'b0;
                    stimulus_done = 1;
                end
            end
        end
    end

    // Monitor: checks each result transfer and throttles ready.
    always @(posedge clk)
    begin
        angle_res_t exp_r;
        if (rst_n)
        begin
            if (angle.valid && angle.ready)
            begin
                results_seen = results_seen + 1;
                if (expected_angles.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Unexpected result: cos %0d angle %0d",
                                 angle.half_angle_cos, angle.angle_deg);
                end
                else
                begin
                    exp_r = expected_angles.pop_front();
                    if (exp_r.half_angle_cos !== angle.half_angle_cos
                        || exp_r.angle_deg !== angle.angle_deg)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("Result %0d mismatch: cos exp %0d got %0d, angle exp %0d got %0d",
                                     results_seen, exp_r.half_angle_cos, angle.half_angle_cos,
                                     exp_r.angle_deg, angle.angle_deg);
                    end
                end
                recv_gap = draw_gap();
            end
            // One long hold-off so that the pipeline fills and stalls its input.
            if (!hold_done && results_seen == 300)
            begin
                hold_done = 1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                angle.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                angle.ready <= 1'b0;
            end
            else
                angle.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((quat.valid && quat.ready) || (angle.valid && angle.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // End of run: drain expectations, let the bench run on so that stray results show, then report.
    initial
    begin
        wait (stimulus_done);
        wait (expected_angles.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_angles.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/cma_pkg.sv
design/cma_quat_if.sv
design/cma_angle_if.sv
design/cma_product.sv
design/cma_cosine.sv
design/cma_acos_lut.sv
design/cubic_misorientation_angle_unit.sv
design/cma_checker.sv
tb/tb_top.sv
